// ===== rtl/core/rbb_pkg.sv =====
// Package for the row box blur: shared constants and types.
// No dependencies.
package rbb_pkg;

  localparam int unsigned MaxRadius   = 15;
  localparam int unsigned MaxRowWidth = 4096;
  localparam int unsigned Channels    = 4;
  localparam int unsigned ChanW       = 8;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = 13;
  localparam int unsigned QueueDepth  = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CfgRowWidth  = 1'b0,
    CfgBlurRadius = 1'b1
  } cfg_idx_e;

  typedef logic [Channels-1:0][ChanW-1:0] pixel_t;

endpackage

// ===== rtl/core/rbb_if.sv =====
// Stream and configuration channel interfaces for the row box blur.
// Depends on rbb_pkg.
interface rbb_pix_if;
  logic                 valid;
  logic                 ready;
  logic [rbb_pkg::ChanW-1:0] chan0;
  logic [rbb_pkg::ChanW-1:0] chan1;
  logic [rbb_pkg::ChanW-1:0] chan2;
  logic [rbb_pkg::ChanW-1:0] chan3;
  modport source (output valid, chan0, chan1, chan2, chan3, input ready);
  modport sink   (input valid, chan0, chan1, chan2, chan3, output ready);
endinterface

interface rbb_out_if;
  logic                 valid;
  logic                 ready;
  logic [rbb_pkg::ChanW-1:0] chan0;
  logic [rbb_pkg::ChanW-1:0] chan1;
  logic [rbb_pkg::ChanW-1:0] chan2;
  logic [rbb_pkg::ChanW-1:0] chan3;
  logic                 row_end;
  modport source (output valid, chan0, chan1, chan2, chan3, row_end, input ready);
  modport sink   (input valid, chan0, chan1, chan2, chan3, row_end, output ready);
endinterface

interface rbb_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [rbb_pkg::CfgIdxW-1:0]    index;
  logic [rbb_pkg::CfgDataW-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/rbb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rbb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/core/rbb_front.sv =====
// Front end of the row box blur: accepts pixels, tracks the row position and
// classifies each into a work item for the back end. Depends on rbb_pkg.
module rbb_front #(
  parameter int unsigned MaxRadius   = rbb_pkg::MaxRadius,
  parameter int unsigned MaxRowWidth = rbb_pkg::MaxRowWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [12:0]        row_width_i,
  input  logic [3:0]         blur_radius_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rbb_pkg::pixel_t    in_pix_i,
  output logic               wr_valid_o,
  input  logic               wr_ready_i,
  output logic [$clog2(MaxRowWidth+1)-1:0] wr_n_o,
  output logic [$clog2(MaxRowWidth+1)-1:0] wr_w_o,
  output logic [$clog2(MaxRadius+1)-1:0]   wr_r_o,
  output rbb_pkg::pixel_t    wr_pix_o
);
  localparam int unsigned CntW = $clog2(MaxRowWidth+1);
  localparam int unsigned RadW = $clog2(MaxRadius+1);

  logic [CntW-1:0] n_q, n_d, w_q, w_d, w_cur;
  logic [RadW-1:0] r_q, r_d, r_cur;
  logic [CntW-1:0] w_raw, half;
  logic [CntW:0]   r_req;
  logic            fire;

  assign in_ready_o = wr_ready_i;
  assign fire       = in_valid_i & wr_ready_i;

  always_comb begin
    if (32'(row_width_i) > MaxRowWidth) w_raw = CntW'(MaxRowWidth);
    else if (row_width_i == '0)          w_raw = CntW'(1);
    else                                 w_raw = CntW'(row_width_i);
    half  = w_raw >> 1;
    r_req = (32'(blur_radius_i) > MaxRadius) ? (CntW+1)'(MaxRadius)
                                             : (CntW+1)'(blur_radius_i);
    if (half == '0) r_cur = '0;
    else if (r_req > (CntW+1)'(half - CntW'(1))) r_cur = RadW'(half - CntW'(1));
    else r_cur = RadW'(r_req);
    w_cur = (n_q == '0) ? w_raw : w_q;
    w_d = w_cur;
    r_d = (n_q == '0) ? r_cur : r_q;
    n_d = (n_q + CntW'(1) >= w_cur) ? '0 : n_q + CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
      w_q <= '0;
      r_q <= '0;
    end else if (fire) begin
      n_q <= n_d;
      w_q <= w_d;
      r_q <= r_d;
    end
  end

  assign wr_valid_o = in_valid_i;
  assign wr_n_o     = n_q;
  assign wr_w_o     = w_cur;
  assign wr_r_o     = r_d;
  assign wr_pix_o   = in_pix_i;
endmodule

// ===== rtl/core/rbb_queue.sv =====
// Small FIFO that decouples the front and back ends of the row box blur.
// Depends on rbb_pkg.
module rbb_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = rbb_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [Width-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [Width-1:0] pop_data_o
);
  localparam int unsigned AW = $clog2(Depth);
  logic [Width-1:0] buf_q [Depth];
  logic [AW-1:0]    wp_q, rp_q;
  logic [AW:0]      cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != (AW+1)'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_data_o   = buf_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wp_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (32'(wp_q) == Depth-1) ? '0 : wp_q + AW'(1);
      if (pop)  rp_q <= (32'(rp_q) == Depth-1) ? '0 : rp_q + AW'(1);
      cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule

// ===== rtl/core/rbb_back.sv =====
// Back end of the row box blur: window sums, pixel ring, drain sequencer and
// divider by the window diameter. Depends on rbb_pkg and rbb_ram.
module rbb_back #(
  parameter int unsigned MaxRadius   = rbb_pkg::MaxRadius,
  parameter int unsigned MaxRowWidth = rbb_pkg::MaxRowWidth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wk_valid_i,
  output logic            wk_ready_o,
  input  logic [$clog2(MaxRowWidth+1)-1:0] wk_n_i,
  input  logic [$clog2(MaxRowWidth+1)-1:0] wk_w_i,
  input  logic [$clog2(MaxRadius+1)-1:0]   wk_r_i,
  input  rbb_pkg::pixel_t wk_pix_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rbb_pkg::pixel_t out_pix_o,
  output logic            out_last_o
);
  localparam int unsigned CntW  = $clog2(MaxRowWidth+1);
  localparam int unsigned RadW  = $clog2(MaxRadius+1);
  // Ring depth rounded up to a power of two so the ring index is the low bits.
  localparam int unsigned Ring  = 2**$clog2(2*MaxRadius+2);
  localparam int unsigned RingW = $clog2(Ring);
  localparam int unsigned SumW  = $clog2((2*MaxRadius+1)*255+1);
  localparam int unsigned Ch    = rbb_pkg::Channels;
  localparam int unsigned CW    = rbb_pkg::ChanW;

  // Sequencer states: fetch reads the older pixel, add updates the sums,
  // div runs the restoring divider, out presents the result.
  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StFetch = 5'b00010,
    StAdd   = 5'b00100,
    StDiv   = 5'b01000,
    StOut   = 5'b10000
  } st_e;

  st_e st_q, st_d;
  logic [CntW-1:0] n_q, w_q, k_q;
  logic [RadW-1:0] r_q;
  logic            drain_q, emit_cur_q;
  rbb_pkg::pixel_t pix_q, first_q;
  logic [Ch-1:0][SumW-1:0] sum_q;
  logic [Ch-1:0][SumW-1:0] rem_q;
  logic [Ch-1:0][CW-1:0]   quo_q;
  logic [$clog2(CW+1)-1:0] bit_q;
  logic [SumW+CW-1:0]      dsh;
  logic                    last_q;

  logic [RingW-1:0] raddr, waddr;
  logic [31:0]      rdata;
  logic             we;
  logic [CntW-1:0]  opos;
  logic             obefore;

  // Older position for the current step: input step uses n-2r-1, drain
  // step uses k-r-1; before the row the first pixel stands in.
  always_comb begin
    if (!drain_q) begin
      obefore = n_q < (CntW'(r_q) << 1) + CntW'(1);
      opos    = n_q - (CntW'(r_q) << 1) - CntW'(1);
    end else begin
      obefore = k_q < CntW'(r_q) + CntW'(1);
      opos    = k_q - CntW'(r_q) - CntW'(1);
    end
  end
  assign raddr = RingW'(opos);
  assign waddr = RingW'(n_q);
  assign we    = (st_q == StAdd) && !drain_q;

  rbb_ram #(.Width(32), .Depth(Ring)) u_ring (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(pix_q),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign wk_ready_o  = (st_q == StIdle);
  assign out_valid_o = (st_q == StOut);
  assign out_pix_o   = quo_q;
  assign out_last_o  = last_q;

  logic [RadW:0] diam;
  assign diam = {r_q, 1'b1};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      sum_q <= '0;
      first_q <= '0;
      pix_q <= '0;
      rem_q <= '0;
      quo_q <= '0;
      drain_q <= 1'b0;
      n_q <= '0; w_q <= '0; r_q <= '0; k_q <= '0;
      emit_cur_q <= 1'b0; last_q <= 1'b0; bit_q <= '0;
    end else begin
      case (st_q)
        StIdle: if (wk_valid_i) begin
          n_q <= wk_n_i; w_q <= wk_w_i; r_q <= wk_r_i;
          pix_q <= wk_pix_i; drain_q <= 1'b0;
          if (wk_n_i == '0) begin
            first_q <= wk_pix_i;
            for (int c = 0; c < Ch; c++)
              sum_q[c] <= SumW'(wk_r_i) * SumW'(wk_pix_i[c]);
          end
          st_q <= StFetch;
        end
        StFetch: begin
          // The ring address is stable now; its data arrives next cycle.
          st_q <= StAdd;
        end
        StAdd: begin
          // Ring read data for this step's older pixel is valid now.
          for (int c = 0; c < Ch; c++) begin
            if (!drain_q && n_q <= CntW'(r_q))
              sum_q[c] <= sum_q[c] + SumW'(pix_q[c]);
            else
              sum_q[c] <= sum_q[c] + SumW'(pix_q[c])
                          - SumW'(obefore ? first_q[c] : rdata[c*CW +: CW]);
          end
          if (!drain_q) begin
            emit_cur_q <= n_q >= CntW'(r_q);
            last_q     <= (n_q - CntW'(r_q)) == (w_q - CntW'(1));
          end else begin
            emit_cur_q <= 1'b1;
            last_q     <= k_q == w_q - CntW'(1);
          end
          st_q <= StDiv;
          bit_q <= '0;
        end
        StDiv: begin
          if (bit_q == '0 && !emit_cur_q) begin
            st_q <= StIdle;
            if (n_q + CntW'(1) >= w_q && r_q != '0) begin
              drain_q <= 1'b1; k_q <= w_q - CntW'(r_q); st_q <= StFetch;
            end
          end else if (bit_q == '0) begin
            for (int c = 0; c < Ch; c++) rem_q[c] <= sum_q[c];
            bit_q <= bit_q + 1'b1;
          end else begin
            // One quotient bit per cycle, most significant first.
            for (int c = 0; c < Ch; c++) begin
              if (rem_q[c] >= SumW'(dsh)) begin
                rem_q[c] <= rem_q[c] - SumW'(dsh);
                quo_q[c][CW - 32'(bit_q)] <= 1'b1;
              end else begin
                quo_q[c][CW - 32'(bit_q)] <= 1'b0;
              end
            end
            if (32'(bit_q) == CW) st_q <= StOut;
            else bit_q <= bit_q + 1'b1;
          end
        end
        StOut: if (out_ready_i) begin
          st_q <= StIdle;
          if (!drain_q) begin
            if (n_q + CntW'(1) >= w_q && r_q != '0) begin
              drain_q <= 1'b1; k_q <= w_q - CntW'(r_q); st_q <= StFetch;
            end
          end else if (k_q != w_q - CntW'(1)) begin
            k_q <= k_q + CntW'(1); st_q <= StFetch;
          end
        end
        default: st_q <= StIdle;
      endcase
    end
  end

  // Divisor shifted to the weight of the current quotient bit.
  assign dsh = (SumW+CW)'(diam) << (CW - 32'(bit_q));
endmodule

// ===== rtl/core/row_box_blur_argb.sv =====
// Top level of the row box blur: horizontal running-sum box filter on ARGB.
// Depends on rbb_pkg, rbb_if, rbb_front, rbb_queue and rbb_back.
//
//   channel  | dir | beat contents
//   ---------+-----+-----------------------------------------
//   pix      | in  | chan0..chan3, one pixel of the row
//   cfg      | in  | index (0 row_width, 1 blur_radius), data
//   res      | out | chan0..chan3 blurred, row_end
//
// A pixel that yields a result passes through the back end in order: the accept,
// one ring read, one sum update, the divide (a load and eight quotient bits
// by 2r+1) and the output beat. A pixel that yields no result ends after the
// sum update; the r drain results after the last pixel skip the accept.
// Reset clears all control state; the pixel ring needs no clearing since
// only entries of the current row are read. Input and output stall
// independently through the queue between front and back.
module row_box_blur_argb #(
  parameter int unsigned MaxRadius   = rbb_pkg::MaxRadius,
  parameter int unsigned MaxRowWidth = rbb_pkg::MaxRowWidth
) (
  input  logic clk_i,
  input  logic rst_ni,
  rbb_pix_if.sink   pix,
  rbb_cfg_if.sink   cfg,
  rbb_out_if.source res
);
  localparam int unsigned CntW = $clog2(MaxRowWidth+1);
  localparam int unsigned RadW = $clog2(MaxRadius+1);
  localparam int unsigned QW   = 2*CntW + RadW + 32;

  logic [12:0] row_width_q;
  logic [3:0]  blur_radius_q;

  // Register writes; indexes beyond the list are dropped.
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_width_q   <= 13'd1;
      blur_radius_q <= 4'd1;
    end else if (cfg.valid) begin
      case (rbb_pkg::cfg_idx_e'(cfg.index))
        rbb_pkg::CfgRowWidth:   row_width_q   <= cfg.data;
        rbb_pkg::CfgBlurRadius: blur_radius_q <= cfg.data[3:0];
        default: ;
      endcase
    end
  end

  rbb_pkg::pixel_t in_pix, wr_pix, bk_pix, o_pix;
  logic wr_valid, wr_ready, bk_valid, bk_ready;
  logic [CntW-1:0] wr_n, wr_w, bk_n, bk_w;
  logic [RadW-1:0] wr_r, bk_r;
  logic [QW-1:0]   bk_data;

  assign in_pix = {pix.chan3, pix.chan2, pix.chan1, pix.chan0};

  rbb_front #(.MaxRadius(MaxRadius), .MaxRowWidth(MaxRowWidth)) u_front (
    .clk_i, .rst_ni, .row_width_i(row_width_q), .blur_radius_i(blur_radius_q),
    .in_valid_i(pix.valid), .in_ready_o(pix.ready), .in_pix_i(in_pix),
    .wr_valid_o(wr_valid), .wr_ready_i(wr_ready), .wr_n_o(wr_n),
    .wr_w_o(wr_w), .wr_r_o(wr_r), .wr_pix_o(wr_pix)
  );

  rbb_queue #(.Width(QW)) u_queue (
    .clk_i, .rst_ni, .push_valid_i(wr_valid), .push_ready_o(wr_ready),
    .push_data_i({wr_n, wr_w, wr_r, wr_pix}), .pop_valid_o(bk_valid),
    .pop_ready_i(bk_ready), .pop_data_o(bk_data)
  );
  assign {bk_n, bk_w, bk_r, bk_pix} = bk_data;

  rbb_back #(.MaxRadius(MaxRadius), .MaxRowWidth(MaxRowWidth)) u_back (
    .clk_i, .rst_ni, .wk_valid_i(bk_valid), .wk_ready_o(bk_ready),
    .wk_n_i(bk_n), .wk_w_i(bk_w), .wk_r_i(bk_r), .wk_pix_i(bk_pix),
    .out_valid_o(res.valid), .out_ready_i(res.ready), .out_pix_o(o_pix),
    .out_last_o(res.row_end)
  );

  assign res.chan0 = o_pix[0];
  assign res.chan1 = o_pix[1];
  assign res.chan2 = o_pix[2];
  assign res.chan3 = o_pix[3];
endmodule
